>>> hdl/g3js_pkg.sv
// ----------------------------------------------------------------------------
// g3js_pkg
// shared constants, codes and types of the 3-d stencil sparsity walker
// ----------------------------------------------------------------------------
package g3js_pkg;

	localparam int MAX_SPECIES = 16;
	localparam int MAX_DIM     = 256;
	localparam int MAX_ROW     = 22;

	localparam int COL_W = 29;
	localparam int CNT_W = 5;
	localparam int IDX_W = 5;

	// register indexes
	localparam logic [2:0] CFG_SPECIES = 3'd0;
	localparam logic [2:0] CFG_SIZE_X  = 3'd1;
	localparam logic [2:0] CFG_SIZE_Y  = 3'd2;
	localparam logic [2:0] CFG_SIZE_Z  = 3'd3;
	localparam logic [2:0] CFG_CYC_X   = 3'd4;
	localparam logic [2:0] CFG_CYC_Y   = 3'd5;
	localparam logic [2:0] CFG_CYC_Z   = 3'd6;
	localparam logic [2:0] CFG_CAP     = 3'd7;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW = 2'd1;
	localparam logic [1:0] STAT_FINISHED = 2'd2;

	typedef struct packed {
		logic             clr;
		logic             chk;
		logic [COL_W-1:0] cand;
	} row_ctl_t;

	function automatic logic [8:0] clamp_dim(input logic [8:0] v);
		logic [8:0] r;
		if (v == 9'd0) r = 9'd1;
		else if (v > 9'(MAX_DIM)) r = 9'(MAX_DIM);
		else r = v;
		return r;
	endfunction

	function automatic logic [4:0] clamp_species(input logic [4:0] v);
		logic [4:0] r;
		if (v == 5'd0) r = 5'd1;
		else if (v > 5'(MAX_SPECIES)) r = 5'(MAX_SPECIES);
		else r = v;
		return r;
	endfunction

endpackage

>>> hdl/g3js_mul.sv
// ----------------------------------------------------------------------------
// g3js_mul
// shared registered multiplier for the per-cell index products
// ----------------------------------------------------------------------------
module g3js_mul (
	input  logic                       clk,
	input  logic [8:0]                 a,
	input  logic [24:0]                b,
	output logic [g3js_pkg::COL_W-1:0] p
);

	logic [33:0] prod;

	assign prod = {25'd0, a} * {9'd0, b};

	always_ff @(posedge clk) begin
		p <= prod[g3js_pkg::COL_W-1:0];
	end

endmodule

>>> hdl/g3js_row.sv
// ----------------------------------------------------------------------------
// g3js_row
// row column store with duplicate check against earlier columns
// ----------------------------------------------------------------------------
module g3js_row (
	input  logic                       clk,
	input  logic                       arst_n,
	input  g3js_pkg::row_ctl_t         ctl,
	input  logic [g3js_pkg::IDX_W-1:0] rd_idx,
	output logic [g3js_pkg::COL_W-1:0] rd_data,
	output logic [g3js_pkg::CNT_W-1:0] cnt
);

	logic [g3js_pkg::COL_W-1:0] row_q [g3js_pkg::MAX_ROW];
	logic [g3js_pkg::CNT_W-1:0] cnt_q;
	logic                       hit;

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < g3js_pkg::MAX_ROW; i++) begin
			if ((g3js_pkg::CNT_W'(i) < cnt_q) && (row_q[i] == ctl.cand)) hit = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.clr) begin
			cnt_q <= '0;
		end else if (ctl.chk && !hit && (cnt_q < g3js_pkg::CNT_W'(g3js_pkg::MAX_ROW))) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clr && ctl.chk && !hit && (cnt_q < g3js_pkg::CNT_W'(g3js_pkg::MAX_ROW))) begin
			row_q[cnt_q] <= ctl.cand;
		end
	end

	assign rd_data = (rd_idx < g3js_pkg::IDX_W'(g3js_pkg::MAX_ROW)) ? row_q[rd_idx] : '0;
	assign cnt     = cnt_q;

endmodule

>>> hdl/grid_3d_jacobian_sparsity.sv
// ----------------------------------------------------------------------------
// grid_3d_jacobian_sparsity
// throughput: one request at a time; the shared multiplier runs seven
//   products per cell, then one candidate per cycle is checked against the
//   row store, then one column per cycle is sent while the output is free
// status-only requests (finished or overflow) go from idle to the check state,
//   which loads their result into the output register once that register is free
// reset: asynchronous, active low; registers to their defaults, walk at cell one
// ----------------------------------------------------------------------------
module grid_3d_jacobian_sparsity (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [28:0] column, [60:29] row_pointer, [63:61] zero
	output logic        m_tlast,
	output logic [1:0]  m_tuser,   // [1:0] status
	// register write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CW = g3js_pkg::COL_W;

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CHK  = 4'd1;
	localparam logic [3:0] ST_MUL  = 4'd2;
	localparam logic [3:0] ST_ADD1 = 4'd3;
	localparam logic [3:0] ST_ADD2 = 4'd4;
	localparam logic [3:0] ST_BLD  = 4'd5;
	localparam logic [3:0] ST_DRN  = 4'd6;
	localparam logic [3:0] ST_ACC  = 4'd7;
	localparam logic [3:0] ST_EMIT = 4'd8;

	// configuration registers
	logic [4:0]  species_q;
	logic [8:0]  size_x_q, size_y_q, size_z_q;
	logic        cyc_x_q, cyc_y_q, cyc_z_q;
	logic [31:0] cap_q;

	// walk state
	logic [3:0]    sp_q;
	logic [7:0]    px_q, py_q, pz_q;
	logic [CW-1:0] cell_q;
	logic [31:0]   ecnt_q;
	logic          halted_q;

	// sequencer
	logic [3:0] state_q;
	logic [2:0] mop_q;
	logic       mph_q;
	logic [2:0] k_q;
	logic       sph_q;
	logic [3:0] l_q;
	logic [g3js_pkg::IDX_W-1:0] idx_q;

	// per-cell products and sums
	logic [24:0]   sx_q, nt_q;
	logic [CW-1:0] isp_q, xs_q, yn_q, xm_q, ym_q, pt_q, ispt_q, acc_q;

	// candidate stage
	logic [CW-1:0] cand_s1;
	logic          cv_s1;

	// output register
	logic          ov_q, last_q;
	logic [CW-1:0] col_q;
	logic [31:0]   rp_q;
	logic [1:0]    stat_q;

	logic [4:0] nsp;
	logic [8:0] nx, ny, nz, x9, y9, z9;
	logic [CW-1:0] sx29, nz29, z29;

	assign nsp  = g3js_pkg::clamp_species(species_q);
	assign nx   = g3js_pkg::clamp_dim(size_x_q);
	assign ny   = g3js_pkg::clamp_dim(size_y_q);
	assign nz   = g3js_pkg::clamp_dim(size_z_q);
	assign x9   = {1'b0, px_q};
	assign y9   = {1'b0, py_q};
	assign z9   = {1'b0, pz_q};
	assign sx29 = {4'd0, sx_q};
	assign nz29 = {20'd0, nz};
	assign z29  = {21'd0, pz_q};

	// shared multiplier operand selection
	logic [8:0]    mul_a;
	logic [24:0]   mul_b;
	logic [CW-1:0] mul_p;

	always_comb begin
		case (mop_q)
			3'd0: begin mul_a = ny;           mul_b = {16'd0, nz}; end
			3'd1: begin mul_a = nx;           mul_b = sx_q;        end
			3'd2: begin mul_a = {5'd0, sp_q}; mul_b = nt_q;        end
			3'd3: begin mul_a = x9;           mul_b = sx_q;        end
			3'd4: begin mul_a = y9;           mul_b = {16'd0, nz}; end
			3'd5: begin mul_a = nx - 9'd1;    mul_b = sx_q;        end
			3'd6: begin mul_a = ny - 9'd1;    mul_b = {16'd0, nz}; end
			default: begin mul_a = '0;        mul_b = '0;          end
		endcase
	end

	g3js_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// candidate column: a + b - c, wrapping at the column width
	logic          cv;
	logic [CW-1:0] ca, cb, cc, cand;

	always_comb begin
		cv = 1'b1;
		ca = cell_q;
		cb = '0;
		cc = '0;
		if (sph_q) begin
			cv = ({1'b0, l_q} != {1'b0, sp_q});
			ca = acc_q;
		end else begin
			case (k_q)
				3'd0: ;
				3'd1: if (z9 + 9'd1 < nz) cb = 29'd1;
					else begin cv = cyc_z_q; ca = ispt_q; cc = z29; end
				3'd2: if (y9 + 9'd1 < ny) cb = nz29;
					else begin cv = cyc_y_q; ca = ispt_q; cc = yn_q; end
				3'd3: if (x9 + 9'd1 < nx) cb = sx29;
					else begin cv = cyc_x_q; ca = ispt_q; cc = xs_q; end
				3'd4: if (px_q != 8'd0) cc = sx29;
					else begin cv = cyc_x_q; ca = ispt_q; cb = xm_q; cc = xs_q; end
				3'd5: if (py_q != 8'd0) cc = nz29;
					else begin cv = cyc_y_q; ca = ispt_q; cb = ym_q; cc = yn_q; end
				3'd6: if (pz_q != 8'd0) cc = 29'd1;
					else begin cv = cyc_z_q; ca = ispt_q; cb = nz29; cc = z29 + 29'd1; end
				default: cv = 1'b0;
			endcase
		end
		cand = ca + cb - cc;
	end

	// row store
	g3js_pkg::row_ctl_t     row_ctl;
	logic [CW-1:0]          row_data;
	logic [g3js_pkg::CNT_W-1:0] row_cnt;

	assign row_ctl.clr  = (state_q == ST_CHK);
	assign row_ctl.chk  = cv_s1;
	assign row_ctl.cand = cand_s1;

	g3js_row u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (row_ctl),
		.rd_idx  (idx_q),
		.rd_data (row_data),
		.cnt     (row_cnt)
	);

	logic        out_free;
	logic        overflow;
	logic [32:0] need;
	logic        out_load;

	assign out_free = !ov_q || m_tready;
	assign need     = {1'b0, ecnt_q} + 33'd6 + {28'd0, nsp};
	assign overflow = need > {1'b0, cap_q};
	// output register takes a new result this cycle
	assign out_load = out_free && (((state_q == ST_CHK) && (halted_q || overflow)) ||
	                               (state_q == ST_EMIT));

	// register writes, always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			species_q <= 5'd1;
			size_x_q  <= 9'd1;
			size_y_q  <= 9'd1;
			size_z_q  <= 9'd1;
			cyc_x_q   <= 1'b0;
			cyc_y_q   <= 1'b0;
			cyc_z_q   <= 1'b0;
			cap_q     <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				g3js_pkg::CFG_SPECIES: species_q <= cfg_data[4:0];
				g3js_pkg::CFG_SIZE_X:  size_x_q  <= cfg_data[8:0];
				g3js_pkg::CFG_SIZE_Y:  size_y_q  <= cfg_data[8:0];
				g3js_pkg::CFG_SIZE_Z:  size_z_q  <= cfg_data[8:0];
				g3js_pkg::CFG_CYC_X:   cyc_x_q   <= cfg_data[0];
				g3js_pkg::CFG_CYC_Y:   cyc_y_q   <= cfg_data[0];
				g3js_pkg::CFG_CYC_Z:   cyc_z_q   <= cfg_data[0];
				g3js_pkg::CFG_CAP:     cap_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sp_q     <= '0;
			px_q     <= '0;
			py_q     <= '0;
			pz_q     <= '0;
			cell_q   <= 29'd1;
			ecnt_q   <= '0;
			halted_q <= 1'b0;
			mop_q    <= '0;
			mph_q    <= 1'b0;
			k_q      <= '0;
			sph_q    <= 1'b0;
			l_q      <= '0;
			idx_q    <= '0;
			sx_q     <= '0;
			nt_q     <= '0;
			isp_q    <= '0;
			xs_q     <= '0;
			yn_q     <= '0;
			xm_q     <= '0;
			ym_q     <= '0;
			pt_q     <= '0;
			ispt_q   <= '0;
			acc_q    <= '0;
			cand_s1  <= '0;
			cv_s1    <= 1'b0;
			ov_q     <= 1'b0;
			last_q   <= 1'b0;
			col_q    <= '0;
			rp_q     <= '0;
			stat_q   <= g3js_pkg::STAT_OK;
		end else begin
			if (out_load) ov_q <= 1'b1;
			else if (m_tready) ov_q <= 1'b0;
			cv_s1 <= (state_q == ST_BLD) && cv;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						// restart request rewinds the walk to cell one
						if (s_tdata[0]) begin
							sp_q     <= '0;
							px_q     <= '0;
							py_q     <= '0;
							pz_q     <= '0;
							cell_q   <= 29'd1;
							ecnt_q   <= '0;
							halted_q <= 1'b0;
						end
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (halted_q || overflow) begin
						// single status-only result
						if (out_free) begin
							col_q    <= '0;
							last_q   <= 1'b1;
							rp_q     <= ecnt_q + 32'd1;
							stat_q   <= halted_q ? g3js_pkg::STAT_FINISHED
							                     : g3js_pkg::STAT_OVERFLOW;
							halted_q <= 1'b1;
							state_q  <= ST_IDLE;
						end
					end else begin
						mop_q   <= '0;
						mph_q   <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// each product: operands in, then the product is captured
					mph_q <= !mph_q;
					if (mph_q) begin
						case (mop_q)
							3'd0: sx_q  <= mul_p[24:0];
							3'd1: nt_q  <= mul_p[24:0];
							3'd2: isp_q <= mul_p;
							3'd3: xs_q  <= mul_p;
							3'd4: yn_q  <= mul_p;
							3'd5: xm_q  <= mul_p;
							3'd6: ym_q  <= mul_p;
							default: ;
						endcase
						if (mop_q == 3'd6) state_q <= ST_ADD1;
						else mop_q <= mop_q + 3'd1;
					end
				end
				ST_ADD1: begin
					// offset of this grid point within one species
					pt_q    <= xs_q + yn_q + z29 + 29'd1;
					state_q <= ST_ADD2;
				end
				ST_ADD2: begin
					ispt_q  <= isp_q + pt_q;
					acc_q   <= pt_q;
					k_q     <= '0;
					sph_q   <= 1'b0;
					l_q     <= '0;
					state_q <= ST_BLD;
				end
				ST_BLD: begin
					cand_s1 <= cand;
					if (!sph_q) begin
						if (k_q == 3'd6) sph_q <= 1'b1;
						else k_q <= k_q + 3'd1;
					end else begin
						// same grid point, next species
						acc_q <= acc_q + {4'd0, nt_q};
						if ({1'b0, l_q} == nsp - 5'd1) state_q <= ST_DRN;
						else l_q <= l_q + 4'd1;
					end
				end
				ST_DRN: begin
					// last candidate checked at this edge
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					ecnt_q <= ecnt_q + {27'd0, row_cnt};
					cell_q <= cell_q + 29'd1;
					idx_q  <= '0;
					// advance z, then y, then x, then species
					if (z9 + 9'd1 < nz) pz_q <= pz_q + 8'd1;
					else begin
						pz_q <= '0;
						if (y9 + 9'd1 < ny) py_q <= py_q + 8'd1;
						else begin
							py_q <= '0;
							if (x9 + 9'd1 < nx) px_q <= px_q + 8'd1;
							else begin
								px_q <= '0;
								if ({1'b0, sp_q} + 5'd1 < nsp) sp_q <= sp_q + 4'd1;
								else begin
									sp_q     <= '0;
									halted_q <= 1'b1;
								end
							end
						end
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						col_q  <= row_data;
						stat_q <= g3js_pkg::STAT_OK;
						if (idx_q == row_cnt - 5'd1) begin
							last_q  <= 1'b1;
							rp_q    <= ecnt_q + 32'd1;
							state_q <= ST_IDLE;
						end else begin
							last_q <= 1'b0;
							rp_q   <= '0;
							idx_q  <= idx_q + 5'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {3'd0, rp_q, col_q};
	assign m_tlast  = last_q;
	assign m_tuser  = stat_q;

endmodule
